[hw/rtl/table_waveform_generator_core_defines.svh]
// Assertion macros for the waveform generator.
// Each check is sampled on the rising edge of clk and is off during rst.
`ifndef TABLE_WAVEFORM_GENERATOR_CORE_DEFINES_SVH
`define TABLE_WAVEFORM_GENERATOR_CORE_DEFINES_SVH

`ifndef SYNTH
`define TWG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("twg assertion failed");
`define TWG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("twg assertion failed");
`else
`define TWG_ASSERT_IMP(lbl, ante, cons)
`define TWG_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/twg_pkg.sv]
`default_nettype none
package twg_pkg;

  localparam int TWG_TABLE_DEPTH = 36;

  localparam int NUM_W    = 16;
  localparam int PREFIX_W = 8;
  localparam int FREQ_W   = 14;
  localparam int IDX_W    = 6;
  localparam int WORD_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam logic [NUM_W-1:0]    NUM_RESET    = 16'd36764;
  localparam logic [PREFIX_W-1:0] PREFIX_RESET = 8'h0F;
  localparam logic [NUM_W-1:0]    PERIOD_RESET = 16'd36764;

  localparam logic [FREQ_W-1:0] FREQ_MIN = 14'd1;
  localparam logic [FREQ_W-1:0] FREQ_MAX = 14'd9999;

  localparam logic [IDX_W-1:0] SINE_WRAP     = 6'd33;
  localparam logic [IDX_W-1:0] SQUARE_WRAP   = 6'd34;
  localparam logic [IDX_W-1:0] TRIANGLE_WRAP = 6'd35;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_NUM = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_PREFIX = 1'd1;

  // Command bytes
  localparam logic [7:0] CH_SINE     = 8'h61;
  localparam logic [7:0] CH_SQUARE   = 8'h73;
  localparam logic [7:0] CH_TRIANGLE = 8'h64;
  localparam logic [7:0] CH_DOWN10   = 8'h31;
  localparam logic [7:0] CH_UP10     = 8'h32;
  localparam logic [7:0] CH_DOWN1    = 8'h33;
  localparam logic [7:0] CH_UP1      = 8'h34;
  localparam logic [7:0] CH_DOWN100  = 8'h35;
  localparam logic [7:0] CH_UP100    = 8'h36;

  typedef enum logic [1:0] {
    WAVE_SINE,
    WAVE_SQUARE,
    WAVE_TRIANGLE
  } wave_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic take_byte;
    logic take_tick;
    logic cfg_we;
    logic div_start;
    logic div_step;
    logic load_out;
    logic load_skid;
    logic skid_to_out;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic freq_byte;
    logic div_last;
  } status_t;

  localparam int TAB_ROWS = 36;
  localparam int SQUARE_HIGH = 17;

  localparam logic [7:0] SINE_TAB [0:TAB_ROWS-1] = '{
    8'd127, 8'd151, 8'd174, 8'd195, 8'd214, 8'd230, 8'd242, 8'd250, 8'd254,
    8'd253, 8'd248, 8'd239, 8'd225, 8'd208, 8'd188, 8'd166, 8'd143, 8'd119,
    8'd95,  8'd73,  8'd52,  8'd34,  8'd19,  8'd8,   8'd2,   8'd0,   8'd2,
    8'd8,   8'd19,  8'd34,  8'd52,  8'd73,  8'd95,  8'd119, 8'd0,   8'd0
  };

  localparam logic [7:0] TRIANGLE_TAB [0:TAB_ROWS-1] = '{
    8'd127, 8'd142, 8'd157, 8'd172, 8'd187, 8'd202, 8'd217, 8'd232, 8'd247,
    8'd254, 8'd239, 8'd224, 8'd210, 8'd195, 8'd180, 8'd165, 8'd150, 8'd135,
    8'd120, 8'd105, 8'd90,  8'd75,  8'd60,  8'd45,  8'd30,  8'd15,  8'd0,
    8'd0,   8'd15,  8'd30,  8'd45,  8'd60,  8'd75,  8'd90,  8'd105, 8'd120
  };

  // Entries past the stored rows read as zero
  function automatic logic [7:0] wave_byte(wave_t w, logic [IDX_W-1:0] k);
    logic [7:0] b;
    b = 8'd0;
    unique case (w)
      WAVE_SQUARE: begin
        if (k < IDX_W'(SQUARE_HIGH)) b = 8'd255;
      end
      WAVE_TRIANGLE: begin
        if (k < IDX_W'(TAB_ROWS)) b = TRIANGLE_TAB[k];
      end
      default: begin
        if (k < IDX_W'(TAB_ROWS)) b = SINE_TAB[k];
      end
    endcase
    return b;
  endfunction

  function automatic logic signed [7:0] freq_delta(logic [7:0] c);
    logic signed [7:0] d;
    unique case (c)
      CH_DOWN10:  d = -8'sd10;
      CH_UP10:    d = 8'sd10;
      CH_DOWN1:   d = -8'sd1;
      CH_UP1:     d = 8'sd1;
      CH_DOWN100: d = -8'sd100;
      CH_UP100:   d = 8'sd100;
      default:    d = 8'sd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/twg_ctrl.sv]
`default_nettype none
module twg_ctrl
  import twg_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 kind,
  output logic                      in_stall,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  output logic                      cfg_ready,
  input  wire status_t              status,
  output cmd_t                      cmd
);

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    out_free       = !out_valid || !out_stall;
    in_stall       = (state != ST_IDLE);
    cfg_ready      = (state == ST_IDLE) && !in_valid;
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (kind) begin
            cmd.take_tick = 1'b1;
            if (status.emit) begin
              if (out_free) begin
                cmd.load_out   = 1'b1;
                out_valid_next = 1'b1;
              end else begin
                // output still blocked: park the word
                cmd.load_skid = 1'b1;
                state_next    = ST_HOLD;
              end
            end
          end else begin
            cmd.take_byte = 1'b1;
            if (status.freq_byte) begin
              cmd.div_start = 1'b1;
              state_next    = ST_DIV;
            end
          end
        end else if (cfg_valid) begin
          cmd.cfg_we = 1'b1;
          if (cfg_index == REG_PERIOD_NUM) begin
            cmd.div_start = 1'b1;
            state_next    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_IDLE;
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd.skid_to_out = 1'b1;
          out_valid_next  = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/twg_dp.sv]
`default_nettype none
module twg_dp
  import twg_pkg::*;
#(
  parameter int TABLE_DEPTH = TWG_TABLE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [7:0]           rx_byte,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [NUM_W-1:0]     cfg_data,
  input  wire cmd_t                 cmd,
  output status_t                   status,
  output logic [WORD_W-1:0]         dac_word
);

  localparam logic [IDX_W-1:0] WRAP_CAP = IDX_W'(TABLE_DEPTH - 1);

  logic [NUM_W-1:0]     period_numerator;
  logic [PREFIX_W-1:0]  command_prefix;
  wave_t                waveform;
  logic [FREQ_W-1:0]    freq_value;
  logic [IDX_W-1:0]     sample_index;
  logic [NUM_W-1:0]     tick_count;
  logic [NUM_W-1:0]     sample_period;
  logic [FREQ_W-1:0]    rem;
  logic [NUM_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [WORD_W-1:0]    skid_word;

  logic [NUM_W-1:0]     num_next;
  logic [NUM_W-1:0]     tick_inc;
  logic [IDX_W-1:0]     idx_inc;
  logic [IDX_W-1:0]     wrap_raw;
  logic [IDX_W-1:0]     wrap_lim;
  logic [WORD_W-1:0]    word;
  logic signed [15:0]   f_sum;
  logic [FREQ_W-1:0]    freq_next;
  logic [FREQ_W:0]      trial;
  logic                 ge;
  logic [FREQ_W-1:0]    rem_next;

  always_comb begin
    num_next = (cmd.cfg_we && cfg_index == REG_PERIOD_NUM) ? cfg_data : period_numerator;
    tick_inc = tick_count + NUM_W'(1);
    idx_inc  = sample_index + IDX_W'(1);
    unique case (waveform)
      WAVE_SQUARE:   wrap_raw = SQUARE_WRAP;
      WAVE_TRIANGLE: wrap_raw = TRIANGLE_WRAP;
      default:       wrap_raw = SINE_WRAP;
    endcase
    wrap_lim = (wrap_raw > WRAP_CAP) ? WRAP_CAP : wrap_raw;
    word     = {command_prefix, wave_byte(waveform, sample_index)};

    // saturate the adjusted frequency to its legal range
    f_sum = $signed({2'b00, freq_value}) + 16'(freq_delta(rx_byte));
    if (f_sum < $signed({2'b00, FREQ_MIN})) freq_next = FREQ_MIN;
    else if (f_sum > $signed({2'b00, FREQ_MAX})) freq_next = FREQ_MAX;
    else freq_next = f_sum[FREQ_W-1:0];

    // one restoring division step
    trial    = {rem, quo[NUM_W-1]};
    ge       = (trial >= {1'b0, freq_value});
    rem_next = ge ? FREQ_W'(trial - {1'b0, freq_value}) : trial[FREQ_W-1:0];

    status.emit      = (tick_inc >= sample_period);
    status.freq_byte = (rx_byte >= CH_DOWN10) && (rx_byte <= CH_UP100);
    status.div_last  = (div_cnt == DIV_CNT_W'(NUM_W - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_numerator <= NUM_RESET;
      command_prefix   <= PREFIX_RESET;
      waveform         <= WAVE_SINE;
      freq_value       <= FREQ_MIN;
      sample_index     <= '0;
      tick_count       <= '0;
      sample_period    <= PERIOD_RESET;
      div_cnt          <= '0;
    end else begin
      if (cmd.cfg_we) begin
        if (cfg_index == REG_PERIOD_NUM) period_numerator <= cfg_data;
        else command_prefix <= cfg_data[PREFIX_W-1:0];
      end
      if (cmd.take_byte) begin
        unique case (rx_byte)
          CH_SINE:     waveform <= WAVE_SINE;
          CH_SQUARE:   waveform <= WAVE_SQUARE;
          CH_TRIANGLE: waveform <= WAVE_TRIANGLE;
          default:     waveform <= waveform;
        endcase
        if (status.freq_byte) freq_value <= freq_next;
      end
      if (cmd.take_tick) begin
        if (status.emit) begin
          tick_count   <= '0;
          sample_index <= (idx_inc >= wrap_lim) ? '0 : idx_inc;
        end else begin
          tick_count <= tick_inc;
        end
      end
      if (cmd.div_start) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
        if (status.div_last) sample_period <= {quo[NUM_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= '0;
      quo <= num_next;
    end else if (cmd.div_step) begin
      rem <= rem_next;
      quo <= {quo[NUM_W-2:0], ge};
    end
    if (cmd.load_out) dac_word <= word;
    else if (cmd.skid_to_out) dac_word <= skid_word;
    if (cmd.load_skid) skid_word <= word;
  end

endmodule
`default_nettype wire

[hw/rtl/table_waveform_generator_core.sv]
// Table waveform generator: command bytes and timer ticks in, DAC words out.
// Input channel (in_valid / in_stall): kind 0 carries a command byte in
//   rx_byte ('a' sine, 's' square, 'd' triangle, '1'..'6' step the frequency
//   value by -10, +10, -1, +1, -100, +100 within 1..9999); kind 1 is one tick.
// Output channel (out_valid / out_stall): one dac_word beat on the tick that
//   completes a sample period: command prefix in the upper byte, table sample
//   in the lower byte. The word is valid the cycle after its tick is taken if the output is free.
// Configuration channel (cfg_valid / cfg_ready): index 0 period numerator,
//   index 1 command prefix. Accepted only while the block is idle.
// Throughput: a tick that parks no word, or a byte that leaves the frequency
//   alone, does not stall the next input. A frequency step or a numerator
//   write does: the sample period is numerator / frequency, recomputed by a
//   one-bit-per-cycle restoring divider (16 steps) while input and config stall.
// Stalls: a waiting output word does not block input; a second word parks in
//   a skid register and input stalls until the first is taken.
// Reset (rst, synchronous): sine, frequency 1, index 0, count 0, numerator
//   36764, prefix 0x0F, sample period 36764, no word pending.
`default_nettype none
`include "table_waveform_generator_core_defines.svh"
module table_waveform_generator_core
  import twg_pkg::*;
#(
  parameter int TABLE_DEPTH = TWG_TABLE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 kind,
  input  wire logic [7:0]           rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [WORD_W-1:0]         dac_word,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [NUM_W-1:0]     cfg_data
);

  cmd_t    cmd;
  status_t status;

  // sequencer: handshakes, divider steps, output and skid occupancy
  twg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .kind      (kind),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // registers, tick counter, table lookup and period divider
  twg_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx_byte),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .dac_word  (dac_word)
  );

  // no input or configuration while the divider runs
  `TWG_ASSERT_IMP(a_div_blocks_io, cmd.div_step, in_stall && !cfg_ready)
  // the divider stops after its last step
  `TWG_ASSERT_NXT(a_div_ends, cmd.div_step && status.div_last, !cmd.div_step)
  // a parked word holds input off while the output is still full
  `TWG_ASSERT_NXT(a_skid_holds, cmd.load_skid, in_stall && out_valid)

endmodule
`default_nettype wire
